FILE: hw/rtl/ovl_pkg.sv
// ordered value list: shared types and codes
// used by ovl_cell and ordered_value_list_core, no dependencies
`timescale 1ns / 1ps

package ovl_pkg;

  typedef enum logic [1:0] {
    KIND_INS_FRONT = 2'd0,
    KIND_INS_BACK  = 2'd1,
    KIND_DELETE    = 2'd2,
    KIND_SEARCH    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_FIELD_W = 5;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic push_front;
    logic push_back;
    logic del;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/ordered_value_list_core.sv
// ordered value list top level: sequencer, count and a chain of ovl_cell
// depends on ovl_pkg and ovl_cell
//
//   channel | dir | tdata fields (lsb up)                        | transfer when
//   in_     | in  | kind[1:0], value[33:2], zero pad [39:34]     | in_tvalid & in_tready
//   out_    | out | status[1:0], found[2], entry_count[7:3]      | out_tvalid & out_tready
//
// each item: on the input transfer every cell compares its entry with the value
// and registers the match; in S_APPLY, once the output register is free, the
// first-match chain across the cells picks the shift and the result is loaded.
// in_tready is high while no item is in flight, including while a result waits.
// a stalled output holds the item in S_APPLY until the output register frees.
// synchronous active-low reset empties the list; entry contents are not cleared.
`timescale 1ns / 1ps

module ordered_value_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // kind[1:0], value[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], found[2], entry_count[7:3]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t                       state_r;
  ovl_pkg::kind_t               kind_r;
  logic [ovl_pkg::VALUE_W-1:0]  value_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         out_valid_r;
  logic [7:0]                   out_data_r, out_data_nxt;

  ovl_pkg::cell_ctl_t           ctl;
  logic [ovl_pkg::VALUE_W-1:0]  in_value;
  logic [ovl_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
  logic                         prior [CAPACITY+1];
  logic                         found;
  logic                         full;
  logic                         in_xfer;
  logic                         out_free;
  logic                         apply;
  logic                         is_insert;
  ovl_pkg::status_t             status;
  logic [31:0]                  count_ext;

  assign in_value  = in_tdata[33:2];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign apply     = (state_r == S_APPLY) && out_free;
  assign full      = (count_r == CAP_C);
  assign found     = prior[CAPACITY];
  assign is_insert = (kind_r == ovl_pkg::KIND_INS_FRONT) || (kind_r == ovl_pkg::KIND_INS_BACK);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    ctl.cmp_en     = in_xfer;
    ctl.push_front = apply && !full && (kind_r == ovl_pkg::KIND_INS_FRONT);
    ctl.push_back  = apply && !full && (kind_r == ovl_pkg::KIND_INS_BACK);
    ctl.del        = apply && (kind_r == ovl_pkg::KIND_DELETE);
  end

  assign prior[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ovl_pkg::VALUE_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = value_r;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    ovl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cmp_value  (in_value),
      .wr_value   (value_r),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .prior_in   (prior[i]),
      .prior_out  (prior[i+1]),
      .data_out   (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    status    = ovl_pkg::ST_OK;
    if (is_insert) begin
      if (full) begin
        status = ovl_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (!found) begin
      status = ovl_pkg::ST_NOT_FOUND;
    end else if (kind_r == ovl_pkg::KIND_DELETE) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext    = {{(32-CNT_W){1'b0}}, count_nxt};
  assign out_data_nxt = {count_ext[ovl_pkg::COUNT_FIELD_W-1:0], found && !is_insert, status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (apply) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= ovl_pkg::kind_t'(in_tdata[1:0]);
      value_r <= in_value;
    end
    if (apply) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: hw/rtl/ovl_cell.sv
// ordered value list: one cell of the entry chain
// holds one entry and its match flag; depends on ovl_pkg
`timescale 1ns / 1ps

module ovl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                           clk,
  input  ovl_pkg::cell_ctl_t             ctl,
  input  logic [ovl_pkg::VALUE_W-1:0]    cmp_value,
  input  logic [ovl_pkg::VALUE_W-1:0]    wr_value,
  input  logic [CNT_W-1:0]               count,
  input  logic [ovl_pkg::VALUE_W-1:0]    left_data,
  input  logic [ovl_pkg::VALUE_W-1:0]    right_data,
  input  logic                           prior_in,
  output logic                           prior_out,
  output logic [ovl_pkg::VALUE_W-1:0]    data_out
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [ovl_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic                        match_r, match_nxt;
  logic                        occupied;

  assign occupied  = (IDX_C < count);
  assign prior_out = prior_in | match_r;
  assign data_out  = data_r;

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = occupied && (cmp_value == data_r);
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.push_front) begin
      data_nxt = left_data;
    end else if (ctl.push_back && (count == IDX_C)) begin
      data_nxt = wr_value;
    end else if (ctl.del && (prior_in || match_r)) begin
      // at or after the first match: pull the right neighbor in
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

FILE: hw/rtl/ovl_checker.sv
// ordered value list: port-level checks, bound to ordered_value_list_core
// depends on ordered_value_list_core ports only
`timescale 1ns / 1ps

module ovl_checker #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in flight: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == 2'd0)
    else $error("found flag with a failing status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd2 |-> out_tdata[7:3] == CAP_LOW)
    else $error("full status while list not full");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

endmodule

bind ordered_value_list_core ovl_checker #(
  .CAPACITY (CAPACITY)
) u_ovl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
